// ----- design/ohm_pkg.sv -----
// shared types, codes and helpers of the open addressing hash map
package ohm_pkg;

	localparam int MAX_CAPACITY_D = 1024;
	localparam int MIN_SLOTS_D    = 64;
	localparam int GROW_FACTOR_D  = 4;
	localparam int LOAD_PERCENT_D = 80;

	localparam int COUNT_W = 11;

	localparam logic [1:0] ACT_SET    = 2'd0;
	localparam logic [1:0] ACT_GET    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	localparam logic [2:0] TAG_UNDEF  = 3'd0;
	localparam logic [2:0] TAG_NULL   = 3'd1;
	localparam logic [2:0] TAG_FALSE  = 3'd2;
	localparam logic [2:0] TAG_TRUE   = 3'd3;
	localparam logic [2:0] TAG_NUMBER = 3'd4;
	localparam logic [2:0] TAG_OBJECT = 3'd5;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_UPDATED   = 3'd1;
	localparam logic [2:0] ST_FOUND     = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_REMOVED   = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	localparam logic [1:0] USE_EMPTY = 2'd0;
	localparam logic [1:0] USE_LIVE  = 2'd1;
	localparam logic [1:0] USE_TOMB  = 2'd2;

	typedef struct packed {
		logic [1:0]  use_mark;
		logic [2:0]  key_kind;
		logic [63:0] key_bits;
		logic [31:0] key_hash;
		logic [2:0]  value_kind;
		logic [63:0] value_bits;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	function automatic logic is_nan(input logic [63:0] x);
		return (&x[62:52]) && (|x[51:0]);
	endfunction

	function automatic logic keys_equal(input logic [2:0] ka, input logic [63:0] pa,
		input logic [2:0] kb, input logic [63:0] pb);
		logic r;
		r = 1'b0;
		if (ka == kb) begin
			if (ka == TAG_NUMBER) begin
				r = !is_nan(pa) && !is_nan(pb) && (((pa | pb) << 1) == 64'd0 || pa == pb);
			end else if (ka == TAG_OBJECT) begin
				r = (pa == pb);
			end else begin
				r = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

// ----- design/ohm_req_if.sv -----
// request channel interface of the hash map
interface ohm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [2:0]  key_kind;
	logic [63:0] key_bits;
	logic [31:0] key_obj_hash;
	logic [2:0]  value_kind;
	logic [63:0] value_bits;

	modport source (output valid, action, key_kind, key_bits, key_obj_hash, value_kind,
		value_bits, input ready);
	modport sink (input valid, action, key_kind, key_bits, key_obj_hash, value_kind,
		value_bits, output ready);
endinterface

// ----- design/ohm_rsp_if.sv -----
// response channel interface of the hash map
interface ohm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [2:0]  result_kind;
	logic [63:0] result_bits;
	logic [10:0] entry_count;

	modport source (output valid, status, result_kind, result_bits, entry_count,
		input ready);
	modport sink (input valid, status, result_kind, result_bits, entry_count,
		output ready);
endinterface

// ----- design/ohm_ram.sv -----
// generic simple dual port ram with registered read
module ohm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- design/open_addressing_hash_map_unit.sv -----
// hash map with linear probing over two banks of slots in one ram
//
// channel  role   handshake      payload
// req      sink   valid/ready    action, key_kind, key_bits, key_obj_hash, value_*
// rsp      source valid/ready    status, result_kind, result_bits, entry_count
//
// an item is decoded, its slot index comes from a one bit per cycle remainder unit and each
// probe is one ram read and a check; clear, bad keys and a get or remove on no table go straight
// to the response; a resize clears each slot of the new bank, reads each old slot and re-places
// each live entry by a remainder and probes, and a remove of a live key may add a shrink check;
// reset needs no ram pass: a bank is swept when it becomes active
// req is ready only in idle; a finished item waits in the output register, stalling while full
module open_addressing_hash_map_unit
	#(
	parameter int MAX_CAPACITY = ohm_pkg::MAX_CAPACITY_D,
	parameter int MIN_SLOTS    = ohm_pkg::MIN_SLOTS_D,
	parameter int GROW_FACTOR  = ohm_pkg::GROW_FACTOR_D,
	parameter int LOAD_PERCENT = ohm_pkg::LOAD_PERCENT_D
) (
	input  logic clk,
	input  logic arst_n,
	ohm_req_if.sink   req,
	ohm_rsp_if.source rsp
);
	import ohm_pkg::*;

	localparam int CAP_W = $clog2(MAX_CAPACITY + 1);
	localparam int AW    = $clog2(2 * MAX_CAPACITY);
	localparam int LW    = CAP_W + 8;
	localparam int GW    = CAP_W + 4;
	localparam int RS    = CAP_W + $clog2(GROW_FACTOR);
	localparam int RW    = 2 * CAP_W + 4;
	localparam logic [RW-1:0] RECIP = RW'(((2 ** RS) + GROW_FACTOR - 1) / GROW_FACTOR);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_DIV     = 4'd2;
	localparam logic [3:0] S_PR_INIT = 4'd3;
	localparam logic [3:0] S_PR_RD   = 4'd4;
	localparam logic [3:0] S_PR_CHK  = 4'd5;
	localparam logic [3:0] S_RZ_CLR  = 4'd6;
	localparam logic [3:0] S_RZ_RD   = 4'd7;
	localparam logic [3:0] S_RZ_CHK  = 4'd8;
	localparam logic [3:0] S_SHRINK  = 4'd9;
	localparam logic [3:0] S_RESP    = 4'd10;

	logic [3:0] state_q, div_ret_q;

	logic [1:0]  it_act_q;
	logic [2:0]  it_kk_q, it_vk_q;
	logic [63:0] it_kb_q, it_vb_q;
	logic [31:0] it_oh_q, h_q;

	logic [CAP_W-1:0] cap_q, live_q, nc_q, rz_i_q, idx_q, n_q;
	logic             bank_q, rz_active_q;
	slot_t            rz_q;

	logic [31:0]      dvd_q;
	logic [CAP_W-1:0] dvs_q, rem_q;
	logic [5:0]       cnt_q;

	logic [2:0]  st_q, rk_q;
	logic [63:0] rb_q;

	logic        ov_q;
	logic [2:0]  o_st_q, o_rk_q;
	logic [63:0] o_rb_q;
	logic [10:0] o_cnt_q;

	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	slot_t            ram_wdata, rd;
	logic [SLOT_W-1:0] ram_rdata;

	logic             p_bank;
	logic [CAP_W-1:0] p_cap;
	logic [2:0]       p_kk, p_vk;
	logic [63:0]      p_kb, p_vb;
	logic [31:0]      p_h;
	logic [AW-1:0]    p_addr;
	logic             mode_place, eq;

	logic [31:0]      hash_c;
	logic             grow_need;
	logic [GW-1:0]    grow_prod;
	logic [CAP_W-1:0] nc_grow;
	logic [CAP_W:0]   div_tmp;
	logic             div_ge;
	logic [CAP_W-1:0] div_rem_n;
	logic [RW-1:0]    q_prod;
	logic [CAP_W-1:0] q_cap, nc_shrink;
	logic             shrink_need;
	logic [CAP_W-1:0] live_dec;

	ohm_ram #(.WIDTH(SLOT_W), .DEPTH(2 * MAX_CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd = slot_t'(ram_rdata);

	always_comb begin
		case (it_kk_q)
			TAG_NULL:   hash_c = 32'd2;
			TAG_FALSE:  hash_c = 32'd0;
			TAG_TRUE:   hash_c = 32'd1;
			TAG_NUMBER: hash_c = it_kb_q[31:0] ^ it_kb_q[63:32];
			TAG_OBJECT: hash_c = it_oh_q;
			default:    hash_c = 32'd0;
		endcase
	end

	assign grow_need = ((LW'(live_q) + LW'(1)) * LW'(100) > LW'(cap_q) * LW'(LOAD_PERCENT))
		&& (CAP_W'(cap_q) < CAP_W'(MAX_CAPACITY));

	always_comb begin
		grow_prod = GW'(cap_q) * GW'(GROW_FACTOR);
		if (grow_prod < GW'(MIN_SLOTS)) begin
			grow_prod = GW'(MIN_SLOTS);
		end
		if (grow_prod > GW'(MAX_CAPACITY)) begin
			grow_prod = GW'(MAX_CAPACITY);
		end
		nc_grow = grow_prod[CAP_W-1:0];
	end

	assign div_tmp   = {rem_q, dvd_q[31]};
	assign div_ge    = div_tmp >= {1'b0, dvs_q};
	assign div_rem_n = div_ge ? CAP_W'(div_tmp - {1'b0, dvs_q}) : div_tmp[CAP_W-1:0];

	// capacity over the grow factor by reciprocal multiplication
	assign q_prod      = RW'(cap_q) * RECIP;
	assign q_cap       = q_prod[RS +: CAP_W];
	assign shrink_need = LW'(live_q) * LW'(100) < LW'(q_cap) * LW'(LOAD_PERCENT);
	assign nc_shrink   = (q_cap < CAP_W'(MIN_SLOTS)) ? CAP_W'(MIN_SLOTS) : q_cap;
	assign live_dec    = (live_q != '0) ? live_q - CAP_W'(1) : live_q;

	assign p_bank = rz_active_q ? ~bank_q : bank_q;
	assign p_cap  = rz_active_q ? nc_q : cap_q;
	assign p_kk   = rz_active_q ? rz_q.key_kind : it_kk_q;
	assign p_kb   = rz_active_q ? rz_q.key_bits : it_kb_q;
	assign p_h    = rz_active_q ? rz_q.key_hash : h_q;
	assign p_vk   = rz_active_q ? rz_q.value_kind : it_vk_q;
	assign p_vb   = rz_active_q ? rz_q.value_bits : it_vb_q;
	assign p_addr = (p_bank ? AW'(MAX_CAPACITY) : AW'(0)) + AW'(idx_q);
	assign mode_place = rz_active_q || (it_act_q == ACT_SET);
	assign eq = keys_equal(rd.key_kind, rd.key_bits, p_kk, p_kb);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = p_addr;
		ram_we    = 1'b0;
		ram_waddr = p_addr;
		ram_wdata = rd;
		case (state_q)
			S_PR_RD: begin
				ram_re = 1'b1;
			end
			S_RZ_RD: begin
				ram_re    = rz_i_q != cap_q;
				ram_raddr = (bank_q ? AW'(MAX_CAPACITY) : AW'(0)) + AW'(rz_i_q);
			end
			S_RZ_CLR: begin
				ram_we             = 1'b1;
				ram_waddr          = (bank_q ? AW'(0) : AW'(MAX_CAPACITY)) + AW'(rz_i_q);
				ram_wdata          = rd;
				ram_wdata.use_mark = USE_EMPTY;
			end
			S_PR_CHK: begin
				if (mode_place) begin
					if (rd.use_mark != USE_LIVE) begin
						ram_we    = 1'b1;
						ram_wdata = '{USE_LIVE, p_kk, p_kb, p_h, p_vk, p_vb};
					end else if (eq) begin
						ram_we               = 1'b1;
						ram_wdata.value_kind = p_vk;
						ram_wdata.value_bits = p_vb;
					end
				end else if (rd.use_mark == USE_LIVE && eq && it_act_q == ACT_REMOVE) begin
					ram_we             = 1'b1;
					ram_wdata.use_mark = USE_TOMB;
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready = state_q == S_IDLE;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			it_act_q <= req.action;
			it_kk_q  <= req.key_kind;
			it_kb_q  <= req.key_bits;
			it_oh_q  <= req.key_obj_hash;
			it_vk_q  <= req.value_kind;
			it_vb_q  <= req.value_bits;
		end
		if (state_q == S_RZ_CHK) begin
			rz_q <= rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_ret_q   <= S_IDLE;
			cap_q       <= '0;
			live_q      <= '0;
			bank_q      <= 1'b0;
			rz_active_q <= 1'b0;
			nc_q        <= '0;
			rz_i_q      <= '0;
			idx_q       <= '0;
			n_q         <= '0;
			h_q         <= '0;
			dvd_q       <= '0;
			dvs_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			st_q        <= ST_NOT_FOUND;
			rk_q        <= TAG_UNDEF;
			rb_q        <= '0;
			ov_q        <= 1'b0;
			o_st_q      <= '0;
			o_rk_q      <= '0;
			o_rb_q      <= '0;
			o_cnt_q     <= '0;
		end else begin
			if (ov_q && rsp.ready && state_q != S_RESP) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					h_q  <= hash_c;
					st_q <= ST_NOT_FOUND;
					rb_q <= '0;
					rk_q <= (it_act_q == ACT_REMOVE) ? TAG_NULL : TAG_UNDEF;
					if (it_act_q == ACT_CLEAR) begin
						cap_q   <= '0;
						live_q  <= '0;
						st_q    <= ST_REMOVED;
						rk_q    <= TAG_NULL;
						state_q <= S_RESP;
					end else if (it_kk_q == TAG_UNDEF || it_kk_q > TAG_OBJECT) begin
						state_q <= S_RESP;
					end else if (it_act_q == ACT_SET) begin
						rk_q <= TAG_UNDEF;
						if (grow_need) begin
							nc_q    <= nc_grow;
							rz_i_q  <= '0;
							state_q <= S_RZ_CLR;
						end else begin
							dvd_q     <= hash_c;
							dvs_q     <= cap_q;
							rem_q     <= '0;
							cnt_q     <= 6'd32;
							div_ret_q <= S_PR_INIT;
							state_q   <= S_DIV;
						end
					end else if (cap_q == '0) begin
						state_q <= S_RESP;
					end else begin
						dvd_q     <= hash_c;
						dvs_q     <= cap_q;
						rem_q     <= '0;
						cnt_q     <= 6'd32;
						div_ret_q <= S_PR_INIT;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= div_rem_n;
					dvd_q <= {dvd_q[30:0], div_ge};
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= div_ret_q;
					end
				end
				S_PR_INIT: begin
					idx_q   <= rem_q;
					n_q     <= '0;
					state_q <= S_PR_RD;
				end
				S_PR_RD: begin
					state_q <= S_PR_CHK;
				end
				S_PR_CHK: begin
					if (mode_place) begin
						if (rd.use_mark != USE_LIVE || eq) begin
							if (rz_active_q) begin
								rz_i_q  <= rz_i_q + CAP_W'(1);
								state_q <= S_RZ_RD;
							end else begin
								if (rd.use_mark != USE_LIVE) begin
									live_q <= live_q + CAP_W'(1);
									st_q   <= ST_INSERTED;
								end else begin
									st_q <= ST_UPDATED;
								end
								state_q <= S_RESP;
							end
						end else if (n_q + CAP_W'(1) == p_cap) begin
							if (rz_active_q) begin
								rz_i_q  <= rz_i_q + CAP_W'(1);
								state_q <= S_RZ_RD;
							end else begin
								st_q    <= ST_FULL;
								state_q <= S_RESP;
							end
						end else begin
							n_q     <= n_q + CAP_W'(1);
							idx_q   <= (idx_q + CAP_W'(1) == p_cap) ? '0 : idx_q + CAP_W'(1);
							state_q <= S_PR_RD;
						end
					end else if (rd.use_mark == USE_LIVE && eq) begin
						rk_q <= rd.value_kind;
						rb_q <= rd.value_bits;
						if (it_act_q == ACT_GET) begin
							st_q    <= ST_FOUND;
							state_q <= S_RESP;
						end else begin
							st_q   <= ST_REMOVED;
							live_q <= live_dec;
							if (live_dec == '0) begin
								cap_q   <= '0;
								state_q <= S_RESP;
							end else if (cap_q > CAP_W'(MIN_SLOTS)) begin
								state_q <= S_SHRINK;
							end else begin
								state_q <= S_RESP;
							end
						end
					end else if (rd.use_mark == USE_EMPTY || n_q + CAP_W'(1) == p_cap) begin
						state_q <= S_RESP;
					end else begin
						n_q     <= n_q + CAP_W'(1);
						idx_q   <= (idx_q + CAP_W'(1) == p_cap) ? '0 : idx_q + CAP_W'(1);
						state_q <= S_PR_RD;
					end
				end
				S_SHRINK: begin
					if (shrink_need) begin
						nc_q    <= nc_shrink;
						rz_i_q  <= '0;
						state_q <= S_RZ_CLR;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RZ_CLR: begin
					if (rz_i_q + CAP_W'(1) == nc_q) begin
						rz_i_q  <= '0;
						state_q <= S_RZ_RD;
					end else begin
						rz_i_q <= rz_i_q + CAP_W'(1);
					end
				end
				S_RZ_RD: begin
					if (rz_i_q == cap_q) begin
						bank_q      <= ~bank_q;
						cap_q       <= nc_q;
						rz_active_q <= 1'b0;
						if (it_act_q == ACT_SET) begin
							dvd_q     <= h_q;
							dvs_q     <= nc_q;
							rem_q     <= '0;
							cnt_q     <= 6'd32;
							div_ret_q <= S_PR_INIT;
							state_q   <= S_DIV;
						end else begin
							state_q <= S_RESP;
						end
					end else begin
						state_q <= S_RZ_CHK;
					end
				end
				S_RZ_CHK: begin
					if (rd.use_mark == USE_LIVE) begin
						rz_active_q <= 1'b1;
						dvd_q       <= rd.key_hash;
						dvs_q       <= nc_q;
						rem_q       <= '0;
						cnt_q       <= 6'd32;
						div_ret_q   <= S_PR_INIT;
						state_q     <= S_DIV;
					end else begin
						rz_i_q  <= rz_i_q + CAP_W'(1);
						state_q <= S_RZ_RD;
					end
				end
				S_RESP: begin
					if (!ov_q || rsp.ready) begin
						ov_q    <= 1'b1;
						o_st_q  <= st_q;
						o_rk_q  <= rk_q;
						o_rb_q  <= rb_q;
						o_cnt_q <= COUNT_W'(live_q);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.status      = o_st_q;
	assign rsp.result_kind = o_rk_q;
	assign rsp.result_bits = o_rb_q;
	assign rsp.entry_count = o_cnt_q;

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q <= CAP_W'(MAX_CAPACITY))
		else $error("capacity above limit");

	a_cap_min: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q != '0 |-> cap_q >= CAP_W'(MIN_SLOTS))
		else $error("nonzero capacity below minimum");

	a_live_fits: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= cap_q)
		else $error("live count exceeds capacity");

	a_probe_seq: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PR_CHK |-> $past(state_q) == S_PR_RD)
		else $error("probe check without read");

endmodule
